// ----- sv/tsa_pkg.sv -----
`default_nettype none

package tsa_pkg;

  // Restart codes for the two index widths.
  localparam logic [31:0] RESTART_WIDE   = 32'hFFFF_FFFF;
  localparam logic [31:0] RESTART_NARROW = 32'h0000_FFFF;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_VERTEX_LIMIT = 2'd0;
  localparam logic [1:0] REG_WIDE_INDICES = 2'd1;
  localparam logic [1:0] REG_STRIP_MODE   = 2'd2;

  // Beat positions inside one triangle.
  localparam logic [1:0] BEAT_FIRST  = 2'd0;
  localparam logic [1:0] BEAT_SECOND = 2'd1;
  localparam logic [1:0] BEAT_THIRD  = 2'd2;

  // What one queue entry expands into on the output side.
  typedef enum logic {
    KIND_SINGLE,
    KIND_TRIANGLE
  } entry_kind_t;

  typedef struct packed {
    entry_kind_t kind;
    logic [31:0] v0;
    logic [31:0] v1;
    logic [31:0] v2;
  } queue_entry_t;

  typedef struct packed {
    logic [31:0] vertex_limit;
    logic        wide_indices;
    logic        strip_mode;
  } cfg_t;

  // Handshake between the queue and its neighbors.
  typedef struct packed {
    logic full;
    logic valid;
  } queue_status_t;

endpackage

`default_nettype wire

// ----- sv/tsa_front.sv -----
`default_nettype none

module tsa_front (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire tsa_pkg::cfg_t         cfg,
  input  wire logic                  accept,
  input  wire logic [31:0]           index_value,
  input  wire logic                  new_primitive,
  output logic                       push,
  output tsa_pkg::queue_entry_t      entry
);
  import tsa_pkg::*;

  logic        have_first;
  logic        have_second;
  logic [31:0] first_held;
  logic [31:0] second_held;
  logic        winding_flip;

  logic        have_first_next;
  logic        have_second_next;
  logic [31:0] first_held_next;
  logic [31:0] second_held_next;
  logic        winding_flip_next;

  logic [31:0] restart_code;
  logic        is_restart;
  logic        in_range;
  logic        hf_eff;
  logic        hs_eff;
  logic        wf_eff;
  logic        degenerate;

  // Classify the incoming index.
  assign restart_code = cfg.wide_indices ? RESTART_WIDE : RESTART_NARROW;
  assign is_restart   = (index_value == restart_code);
  assign in_range     = (index_value < cfg.vertex_limit);

  // A new primitive clears the strip before the index is looked at.
  assign hf_eff = have_first & ~new_primitive;
  assign hs_eff = have_second & ~new_primitive;
  assign wf_eff = winding_flip & ~new_primitive;

  assign degenerate = (first_held == second_held) || (second_held == index_value) ||
                      (first_held == index_value);

  // Next strip state and the entry handed to the queue.
  always_comb begin
    have_first_next   = have_first;
    have_second_next  = have_second;
    first_held_next   = first_held;
    second_held_next  = second_held;
    winding_flip_next = winding_flip;
    push              = 1'b0;
    entry.kind        = KIND_SINGLE;
    entry.v0          = index_value;
    entry.v1          = second_held;
    entry.v2          = index_value;
    if (accept) begin
      have_first_next   = hf_eff;
      have_second_next  = hs_eff;
      winding_flip_next = wf_eff;
      if (is_restart) begin
        have_first_next   = 1'b0;
        have_second_next  = 1'b0;
        winding_flip_next = 1'b0;
      end else if (in_range) begin
        if (!cfg.strip_mode) begin
          push = 1'b1;
        end else if (!hf_eff) begin
          first_held_next = index_value;
          have_first_next = 1'b1;
        end else if (!hs_eff) begin
          second_held_next = index_value;
          have_second_next = 1'b1;
        end else begin
          push       = ~degenerate;
          entry.kind = KIND_TRIANGLE;
          entry.v0   = wf_eff ? second_held : first_held;
          entry.v1   = wf_eff ? first_held : second_held;
          first_held_next   = second_held;
          second_held_next  = index_value;
          winding_flip_next = ~wf_eff;
        end
      end
    end
  end

  // Strip state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      have_first   <= 1'b0;
      have_second  <= 1'b0;
      first_held   <= '0;
      second_held  <= '0;
      winding_flip <= 1'b0;
    end else begin
      have_first   <= have_first_next;
      have_second  <= have_second_next;
      first_held   <= first_held_next;
      second_held  <= second_held_next;
      winding_flip <= winding_flip_next;
    end
  end

endmodule

`default_nettype wire

// ----- sv/tsa_queue.sv -----
`default_nettype none

module tsa_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  push,
  input  wire tsa_pkg::queue_entry_t push_entry,
  input  wire logic                  pop,
  output tsa_pkg::queue_entry_t      head,
  output tsa_pkg::queue_status_t     status
);
  import tsa_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  queue_entry_t  slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign head         = slots[rd_ptr];
  assign status.full  = (count == FULL_COUNT);
  assign status.valid = (count != '0);

  // Entry storage; payload needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- sv/tsa_back.sv -----
`default_nettype none

module tsa_back (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire tsa_pkg::queue_entry_t head,
  input  wire logic                  head_valid,
  output logic                       pop,
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [31:0]                m_tdata,
  output logic                       m_tlast
);
  import tsa_pkg::*;

  logic [1:0]  beat_idx;
  logic        load;
  logic        beat_last;
  logic [31:0] beat_value;

  // The output register takes a new beat when it is empty or being taken.
  assign load = (~m_tvalid | m_tready) & head_valid;

  assign beat_last = (head.kind == KIND_SINGLE) || (beat_idx == BEAT_THIRD);
  assign pop       = load & beat_last;

  // Pick the vertex for the current beat of the head entry.
  always_comb begin
    case (beat_idx)
      BEAT_FIRST:  beat_value = head.v0;
      BEAT_SECOND: beat_value = head.v1;
      default:     beat_value = head.v2;
    endcase
  end

  // Output valid and beat counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      beat_idx <= BEAT_FIRST;
    end else if (load) begin
      m_tvalid <= 1'b1;
      beat_idx <= beat_last ? BEAT_FIRST : beat_idx + 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Output payload.
  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= beat_value;
      m_tlast <= beat_last;
    end
  end

endmodule

`default_nettype wire

// ----- sv/triangle_strip_assembler_unit.sv -----
`default_nettype none

// Triangle strip assembler with primitive restart.
// The slave stream carries one vertex index per beat (tdata) and a new-primitive
// flag (tuser). The master stream carries the assembled triangle list, one
// vertex index per beat, with tlast on the final beat that an input produces.
// Registers are to be written over the APB port while the block is idle; the
// block itself does not enforce this. An input beat is classified by the front
// stage in the cycle it is accepted; its entry is then registered in the queue,
// and its output beats go out through the output register. In list mode the
// block passes one index per cycle while the receiver is ready. In strip mode
// every triangle takes three output beats via the single output register; the
// front keeps accepting until the entry queue between front and back is full.
// When the receiver stalls, the output register holds its beat, the queue
// fills, and then s_tready drops.
// Reset clears the strip state, the queue and the output valid, and sets
// vertex_limit to 0, wide_indices to 0 and strip_mode to 1.
module triangle_strip_assembler_unit #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,  // [31:0] index_value
  input  wire logic        s_tuser,  // [0] new_primitive
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,  // [31:0] vertex_out
  output logic             m_tlast,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import tsa_pkg::*;

  cfg_t          cfg;
  logic          cfg_write;
  logic          in_accept;
  logic          q_push;
  logic          q_pop;
  queue_entry_t  q_in;
  queue_entry_t  q_head;
  queue_status_t q_status;

  // Configuration registers.
  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.vertex_limit <= '0;
      cfg.wide_indices <= 1'b0;
      cfg.strip_mode   <= 1'b1;
    end else if (cfg_write) begin
      case (paddr[3:2])
        REG_VERTEX_LIMIT: cfg.vertex_limit <= pwdata;
        REG_WIDE_INDICES: cfg.wide_indices <= pwdata[0];
        REG_STRIP_MODE:   cfg.strip_mode   <= pwdata[0];
        default:          ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_VERTEX_LIMIT: prdata = cfg.vertex_limit;
      REG_WIDE_INDICES: prdata = {31'd0, cfg.wide_indices};
      REG_STRIP_MODE:   prdata = {31'd0, cfg.strip_mode};
      default:          prdata = '0;
    endcase
  end

  // Front stage accepts whenever the queue has room.
  assign s_tready  = ~q_status.full;
  assign in_accept = s_tvalid & s_tready;

  tsa_front u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .accept        (in_accept),
    .index_value   (s_tdata),
    .new_primitive (s_tuser),
    .push          (q_push),
    .entry         (q_in)
  );

  tsa_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_in),
    .pop        (q_pop),
    .head       (q_head),
    .status     (q_status)
  );

  tsa_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (q_head),
    .head_valid (q_status.valid),
    .pop        (q_pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast)
  );

  // The front never pushes into a full queue.
  assert property (@(posedge clk) disable iff (rst) q_push |-> s_tready)
    else $error("entry pushed into a full queue");

  // The back only retires an entry that is present.
  assert property (@(posedge clk) disable iff (rst) q_pop |-> q_status.valid)
    else $error("entry popped from an empty queue");

  // A strip_mode write takes effect at the next edge.
  assert property (@(posedge clk) disable iff (rst)
    (cfg_write && paddr[3:2] == REG_STRIP_MODE) |=> (cfg.strip_mode == $past(pwdata[0])))
    else $error("strip_mode write lost");

  // Output is empty right after reset.
  assert property (@(posedge clk) $past(rst) |-> !m_tvalid)
    else $error("output valid after reset");

endmodule

`default_nettype wire
